[rtl/stereo_delay_line_pitch_shifter_macros.svh]
// Assertion macros used by the RTL core; each expects clk and rst_n in scope.
`ifndef STEREO_DELAY_LINE_PITCH_SHIFTER_MACROS_SVH
`define STEREO_DELAY_LINE_PITCH_SHIFTER_MACROS_SVH

// Same-cycle implication.
`define SDLPS_ASSERT_IMPLIES(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sdlps: implication check failed");

// Next-cycle implication.
`define SDLPS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sdlps: next-cycle check failed");

`endif

[rtl/sdlps_pkg.sv]
package sdlps_pkg;

    typedef longint unsigned u64_t;

    localparam int SAMPLE_W     = 24;
    localparam int FRAC_BITS    = 16;
    localparam int LEN_W        = 14;
    localparam int POS_W        = 30;
    localparam int PHASE_W      = 27;
    localparam int STEP_W       = 18;
    localparam int MIX_W        = 17;
    localparam int GRAIN_W      = 11;
    localparam int INV_W        = 21;
    localparam int CFG_W        = 21;
    localparam int CFG_IDX_W    = 3;
    localparam int ACC_W        = 40;
    localparam int PROD_W       = PHASE_W + INV_W;
    localparam int FADE_ENTRIES = 1024;
    localparam int FADE_AW      = $clog2(FADE_ENTRIES);
    localparam int FADE_SHIFT   = FRAC_BITS + 24 - FADE_AW;
    localparam int GRAIN_MIN    = 16;
    localparam int GRAIN_LIMIT  = 1638;

    localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 24'h800000;
    localparam logic [FRAC_BITS:0]  FRAC_ONE  = 17'(1 << FRAC_BITS);
    localparam logic [FRAC_BITS:0]  FRAC_HALF = 17'(1 << (FRAC_BITS - 1));
    localparam logic [16:0]         Q16_ONE   = 17'd65536;
    localparam logic [16:0]         Q16_HALF  = 17'd32768;

    localparam u64_t Q30_ONE = 64'd1 << 30;
    localparam u64_t PI_Q30  = 64'd3373259426;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE        = 3'd0,
        REG_PITCH_STEP    = 3'd1,
        REG_MIX_LEVEL     = 3'd2,
        REG_GRAIN_LENGTH  = 3'd3,
        REG_GRAIN_INVERSE = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic               enable;
        logic [STEP_W-1:0]  pitch_step;
        logic [MIX_W-1:0]   mix_level;
        logic [GRAIN_W-1:0] grain_length;
        logic [INV_W-1:0]   grain_inverse;
    } cfg_t;

    typedef struct packed {
        logic                bypass;
        logic [SAMPLE_W-1:0] right;
        logic [SAMPLE_W-1:0] left;
    } frame_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WRITE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_TAIL,
        ST_FADE,
        ST_MIX
    } state_t;

    typedef logic [16:0] fade_rom_t [FADE_ENTRIES];

    function automatic fade_rom_t build_fade();
        fade_rom_t rom;
        longint    d;
        u64_t      ad;
        u64_t      u;
        u64_t      u2;
        u64_t      t;
        u64_t      s;
        u64_t      v;
        u64_t      f;
        for (int i = 0; i < FADE_ENTRIES; i++)
        begin
            d  = 2 * longint'(i) - longint'(FADE_ENTRIES);
            ad = u64_t'((d < 0) ? -d : d);
            u  = PI_Q30 * ad / (2 * FADE_ENTRIES);
            u2 = (u * u) >> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - ((u2 * t) >> 30) / 110;
            t  = Q30_ONE - ((u2 * t) >> 30) / 72;
            t  = Q30_ONE - ((u2 * t) >> 30) / 42;
            t  = Q30_ONE - ((u2 * t) >> 30) / 20;
            t  = Q30_ONE - ((u2 * t) >> 30) / 6;
            s  = (u * t) >> 30;
            if (s > Q30_ONE)
            begin
                s = Q30_ONE;
            end
            v = (d >= 0) ? Q30_ONE + s : Q30_ONE - s;
            f = (v + 64'd16384) >> 15;
            if (f > 64'd65536)
            begin
                f = 64'd65536;
            end
            rom[i] = 17'(f);
        end
        return rom;
    endfunction

    localparam fade_rom_t FADE_ROM = build_fade();

endpackage

[rtl/sdlps_ram.sv]
module sdlps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sdlps_front.sv]
module sdlps_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            enable,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2*sdlps_pkg::SAMPLE_W-1:0] in_data,
    output logic                            q_valid,
    output sdlps_pkg::frame_t               q_data,
    input  logic                            q_pop
);
    import sdlps_pkg::*;

    frame_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    frame_t     item;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = slot_reg[rd_ptr_reg];

    // classify: tag the request as bypass when processing is off
    always_comb
    begin
        item.bypass = !enable;
        item.left   = in_data[SAMPLE_W-1:0];
        item.right  = in_data[2*SAMPLE_W-1:SAMPLE_W];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

[rtl/sdlps_core.sv]
`include "stereo_delay_line_pitch_shifter_macros.svh"

module sdlps_core #(
    parameter int DEPTH = 16384
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sdlps_pkg::cfg_t                  cfg,
    input  logic                             q_valid,
    input  sdlps_pkg::frame_t                q_data,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2*sdlps_pkg::SAMPLE_W-1:0] out_data
);
    import sdlps_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int GRAIN_MAX = ((DEPTH / 10) < GRAIN_LIMIT) ? (DEPTH / 10) : GRAIN_LIMIT;

    state_t               state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [2*SAMPLE_W-1:0] out_data_reg, out_data_next;

    logic [POS_W-1:0]     rp_reg, rp_next;
    logic [PHASE_W-1:0]   gp_reg, gp_next;
    logic [LEN_W-1:0]     wi_reg, wi_next;
    logic [LEN_W-1:0]     hwm_reg, hwm_next;

    frame_t               frame_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [PHASE_W-1:0]   gq_reg;
    logic [POS_W-1:0]     lq_reg;
    logic [MIX_W-1:0]     m_reg;
    logic [POS_W-1:0]     pos1_reg;
    logic [POS_W-1:0]     pos2_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [FADE_AW-1:0]   fidx_reg;
    logic [16:0]          f1_reg;
    logic                 rdz_reg;
    logic [ACC_W-1:0]     acc_l_reg, acc_r_reg;
    logic [SAMPLE_W-1:0]  tap1_l_reg, tap1_r_reg;
    logic [SAMPLE_W-1:0]  tap2_l_reg, tap2_r_reg;
    logic [ACC_W-1:0]     pf_l_reg, pf_r_reg;
    logic [ACC_W-1:0]     dry_l_reg, dry_r_reg;
    logic [SAMPLE_W-1:0]  wet_l_reg, wet_r_reg;

    logic                 out_free;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [SAMPLE_W-1:0]  ram_q_l, ram_q_r;
    logic [SAMPLE_W-1:0]  d_l, d_r;
    logic [LEN_W-1:0]     rd_idx;
    logic                 rd_zero;

    logic [GRAIN_W-1:0]   g_c;
    logic [LEN_W-1:0]     len_c;
    logic [POS_W-1:0]     rp_c;
    logic [PHASE_W-1:0]   gp_c;
    logic [LEN_W-1:0]     wi_c;
    logic [POS_W:0]       pos2_sum;
    logic [POS_W:0]       rp_sum;
    logic [PHASE_W:0]     gp_sum;
    logic [LEN_W:0]       wi_inc;
    logic [LEN_W-1:0]     i0;
    logic [LEN_W:0]       i0_inc;
    logic [POS_W-1:0]     pos_sel;
    logic                 pick_second;
    logic [FRAC_BITS-1:0] fr1, fr2;
    logic [ACC_W-1:0]     sum_l, sum_r;
    logic [16:0]          f2;
    logic [16:0]          dry_w;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    sdlps_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_left_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (frame_reg.left),
        .raddr (ram_raddr),
        .rdata (ram_q_l)
    );

    sdlps_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_right_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (frame_reg.right),
        .raddr (ram_raddr),
        .rdata (ram_q_r)
    );

    // datapath helpers
    always_comb
    begin
        if (cfg.grain_length < GRAIN_W'(GRAIN_MIN))
        begin
            g_c = GRAIN_W'(GRAIN_MIN);
        end
        else if (cfg.grain_length > GRAIN_W'(GRAIN_MAX))
        begin
            g_c = GRAIN_W'(GRAIN_MAX);
        end
        else
        begin
            g_c = cfg.grain_length;
        end
        len_c = (LEN_W'(g_c) << 3) + (LEN_W'(g_c) << 1);

        rp_c = (rp_reg >= lq_reg) ? '0 : rp_reg;
        gp_c = ((rp_reg >= lq_reg) || (gp_reg >= gq_reg)) ? '0 : gp_reg;
        wi_c = (wi_reg >= len_reg) ? '0 : wi_reg;

        pos2_sum = {1'b0, rp_c} + (POS_W+1)'(gq_reg);
        rp_sum   = {1'b0, rp_c} + (POS_W+1)'(cfg.pitch_step);
        gp_sum   = {1'b0, gp_c} + (PHASE_W+1)'(cfg.pitch_step);
        wi_inc   = {1'b0, wi_c} + (LEN_W+1)'(1);

        pick_second = (state_reg == ST_RD2) || (state_reg == ST_RD3);
        pos_sel     = pick_second ? pos2_reg : pos1_reg;
        i0          = pos_sel[POS_W-1:FRAC_BITS];
        i0_inc      = {1'b0, i0} + (LEN_W+1)'(1);
        if ((state_reg == ST_RD1) || (state_reg == ST_RD3))
        begin
            rd_idx = (i0_inc >= {1'b0, len_reg}) ? '0 : i0_inc[LEN_W-1:0];
        end
        else
        begin
            rd_idx = i0;
        end
        rd_zero   = (rd_idx >= hwm_reg);
        ram_raddr = AW'(rd_idx);
        ram_waddr = AW'(wi_c);

        // never-written entries read as zero, i.e. mid-scale in offset binary
        d_l = rdz_reg ? SIGN_FLIP : (ram_q_l ^ SIGN_FLIP);
        d_r = rdz_reg ? SIGN_FLIP : (ram_q_r ^ SIGN_FLIP);

        fr1   = pos1_reg[FRAC_BITS-1:0];
        fr2   = pos2_reg[FRAC_BITS-1:0];
        f2    = Q16_ONE - f1_reg;
        dry_w = Q16_ONE - m_reg;
        sum_l = '0;
        sum_r = '0;
        unique case (state_reg)
            ST_RD2:
            begin
                sum_l = acc_l_reg + ACC_W'(d_l) * ACC_W'(fr1) + ACC_W'(FRAC_HALF);
                sum_r = acc_r_reg + ACC_W'(d_r) * ACC_W'(fr1) + ACC_W'(FRAC_HALF);
            end
            ST_TAIL:
            begin
                sum_l = acc_l_reg + ACC_W'(d_l) * ACC_W'(fr2) + ACC_W'(FRAC_HALF);
                sum_r = acc_r_reg + ACC_W'(d_r) * ACC_W'(fr2) + ACC_W'(FRAC_HALF);
            end
            ST_FADE:
            begin
                sum_l = pf_l_reg + ACC_W'(tap2_l_reg) * ACC_W'(f2) + ACC_W'(Q16_HALF);
                sum_r = pf_r_reg + ACC_W'(tap2_r_reg) * ACC_W'(f2) + ACC_W'(Q16_HALF);
            end
            ST_MIX:
            begin
                sum_l = dry_l_reg + ACC_W'(wet_l_reg) * ACC_W'(m_reg) + ACC_W'(Q16_HALF);
                sum_r = dry_r_reg + ACC_W'(wet_r_reg) * ACC_W'(m_reg) + ACC_W'(Q16_HALF);
            end
            default:
            begin
                sum_l = '0;
                sum_r = '0;
            end
        endcase
    end

    // sequencer: next state and control
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rp_next        = rp_reg;
        gp_next        = gp_reg;
        wi_next        = wi_reg;
        hwm_next       = hwm_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_data.bypass)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = {q_data.right, q_data.left};
                    end
                    else
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                ram_we  = 1'b1;
                rp_next = (rp_sum >= {1'b0, lq_reg}) ?
                          POS_W'(rp_sum - {1'b0, lq_reg}) : rp_sum[POS_W-1:0];
                gp_next = (gp_sum >= {1'b0, gq_reg}) ?
                          PHASE_W'(gp_sum - {1'b0, gq_reg}) : gp_sum[PHASE_W-1:0];
                wi_next = (wi_inc >= {1'b0, len_reg}) ? '0 : wi_inc[LEN_W-1:0];
                if (wi_inc > {1'b0, hwm_reg})
                begin
                    hwm_next = wi_inc[LEN_W-1:0];
                end
                state_next = ST_RD0;
            end
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_RD3;
            ST_RD3:  state_next = ST_TAIL;
            ST_TAIL: state_next = ST_FADE;
            ST_FADE: state_next = ST_MIX;
            ST_MIX:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {sum_r[ACC_W-1:16] ^ SIGN_FLIP,
                                      sum_l[ACC_W-1:16] ^ SIGN_FLIP};
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rp_reg        <= '0;
            gp_reg        <= '0;
            wi_reg        <= '0;
            hwm_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rp_reg        <= rp_next;
            gp_reg        <= gp_next;
            wi_reg        <= wi_next;
            hwm_reg       <= hwm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        rdz_reg      <= rd_zero;
        if (q_pop)
        begin
            frame_reg <= q_data;
        end
        case (state_reg)
            ST_SETUP:
            begin
                len_reg <= len_c;
                gq_reg  <= {g_c, {FRAC_BITS{1'b0}}};
                lq_reg  <= {len_c, {FRAC_BITS{1'b0}}};
                m_reg   <= (cfg.mix_level > Q16_ONE) ? Q16_ONE : cfg.mix_level;
            end
            ST_WRITE:
            begin
                pos1_reg  <= rp_c;
                pos2_reg  <= (pos2_sum >= {1'b0, lq_reg}) ?
                             POS_W'(pos2_sum - {1'b0, lq_reg}) : pos2_sum[POS_W-1:0];
                prod_reg  <= PROD_W'(gp_c) * PROD_W'(cfg.grain_inverse);
                dry_l_reg <= ACC_W'(frame_reg.left ^ SIGN_FLIP) * ACC_W'(dry_w);
                dry_r_reg <= ACC_W'(frame_reg.right ^ SIGN_FLIP) * ACC_W'(dry_w);
            end
            ST_RD0:
            begin
                fidx_reg <= (prod_reg[PROD_W-1:FADE_SHIFT] >= (PROD_W-FADE_SHIFT)'(FADE_ENTRIES)) ?
                            FADE_AW'(FADE_ENTRIES - 1) : prod_reg[FADE_SHIFT +: FADE_AW];
            end
            ST_RD1:
            begin
                f1_reg    <= FADE_ROM[fidx_reg];
                acc_l_reg <= ACC_W'(d_l) * ACC_W'(FRAC_ONE - 17'(fr1));
                acc_r_reg <= ACC_W'(d_r) * ACC_W'(FRAC_ONE - 17'(fr1));
            end
            ST_RD2:
            begin
                tap1_l_reg <= sum_l[FRAC_BITS +: SAMPLE_W];
                tap1_r_reg <= sum_r[FRAC_BITS +: SAMPLE_W];
            end
            ST_RD3:
            begin
                acc_l_reg <= ACC_W'(d_l) * ACC_W'(FRAC_ONE - 17'(fr2));
                acc_r_reg <= ACC_W'(d_r) * ACC_W'(FRAC_ONE - 17'(fr2));
                pf_l_reg  <= ACC_W'(tap1_l_reg) * ACC_W'(f1_reg);
                pf_r_reg  <= ACC_W'(tap1_r_reg) * ACC_W'(f1_reg);
            end
            ST_TAIL:
            begin
                tap2_l_reg <= sum_l[FRAC_BITS +: SAMPLE_W];
                tap2_r_reg <= sum_r[FRAC_BITS +: SAMPLE_W];
            end
            ST_FADE:
            begin
                wet_l_reg <= sum_l[ACC_W-1:16];
                wet_r_reg <= sum_r[ACC_W-1:16];
            end
            default:
            begin
            end
        endcase
    end

    `SDLPS_ASSERT_IMPLIES(a_pop_only_idle, q_pop, (state_reg == ST_IDLE) && out_free)
    `SDLPS_ASSERT_IMPLIES(a_write_only_in_write, ram_we, state_reg == ST_WRITE)
    `SDLPS_ASSERT_IMPLIES(a_state_in_range, state_reg == ST_RD0,
        (wi_reg < len_reg) && (rp_reg < lq_reg) && (gp_reg < gq_reg))
    `SDLPS_ASSERT_NEXT(a_write_then_read, state_reg == ST_WRITE, state_reg == ST_RD0)

endmodule

[rtl/stereo_delay_line_pitch_shifter.sv]
// Channel   Dir  Payload                                      Handshake
// s_axis    in   tdata[23:0] left_in, tdata[47:24] right_in    tvalid/tready
// m_axis    out  tdata[23:0] left_out, tdata[47:24] right_out  tvalid/tready
// cfg       in   cfg_index selects register, cfg_wdata value  cfg_we, no wait
//
// A processed frame passes SETUP, WRITE, RD0-RD3, TAIL, FADE, MIX; four serial
// reads of each sample store's single read port dominate. Bypass skips them all.
// A two-entry queue decouples input from the back end; the output register
// holds a result while the next request is accepted. Reset is asynchronous and
// needs no clearing pass: a high-water mark makes unwritten entries read zero.
module stereo_delay_line_pitch_shifter #(
    parameter int DEPTH = 16384
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [2*sdlps_pkg::SAMPLE_W-1:0]  s_axis_tdata,  // left_in, right_in
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [2*sdlps_pkg::SAMPLE_W-1:0]  m_axis_tdata,  // left_out, right_out
    input  logic                              cfg_we,
    input  logic [sdlps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sdlps_pkg::CFG_W-1:0]       cfg_wdata
);
    import sdlps_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   q_valid;
    frame_t q_data;
    logic   q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_ENABLE:        cfg_next.enable        = cfg_wdata[0];
                REG_PITCH_STEP:    cfg_next.pitch_step    = cfg_wdata[STEP_W-1:0];
                REG_MIX_LEVEL:     cfg_next.mix_level     = cfg_wdata[MIX_W-1:0];
                REG_GRAIN_LENGTH:  cfg_next.grain_length  = cfg_wdata[GRAIN_W-1:0];
                REG_GRAIN_INVERSE: cfg_next.grain_inverse = cfg_wdata[INV_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= 1'b1;
            cfg_reg.pitch_step    <= 18'd65536;
            cfg_reg.mix_level     <= 17'd65536;
            cfg_reg.grain_length  <= 11'd960;
            cfg_reg.grain_inverse <= 21'd17476;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sdlps_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .enable   (cfg_reg.enable),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    sdlps_core #(.DEPTH(DEPTH)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sdlps_pkg::*;

    localparam int STORE_DEPTH = 16384;
    localparam int IDLE_LIMIT  = 3000;
    localparam int SETTLE      = 24;

    typedef struct {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } stereo_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [2*SAMPLE_W-1:0]      s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [2*SAMPLE_W-1:0]      m_axis_tdata;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_wdata;

    stereo_delay_line_pitch_shifter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // shadow of the shifter state
    logic [SAMPLE_W-1:0] left_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] right_mem [STORE_DEPTH];
    longint unsigned     wr_ptr;
    longint unsigned     rd_pos;
    longint unsigned     phase;
    longint unsigned     fade_lut [FADE_ENTRIES];
    logic                sh_enable;
    logic [STEP_W-1:0]   sh_step;
    logic [MIX_W-1:0]    sh_mix;
    logic [GRAIN_W-1:0]  sh_grain;
    logic [INV_W-1:0]    sh_inverse;

    stereo_t pending_frames [$];
    int      mismatches;
    int      idle_cycles = 0;
    int      send_gap_max;
    int      stall_max;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("%0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic build_fade_lut();
        longint unsigned divs [5] = '{110, 72, 42, 20, 6};
        longint          d;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        for (int i = 0; i < FADE_ENTRIES; i++)
        begin
            d  = 2 * longint'(i) - FADE_ENTRIES;
            u  = PI_Q30 * longint'(d < 0 ? -d : d) / (2 * FADE_ENTRIES);
            u2 = (u * u) >> 30;
            t  = Q30_ONE;
            for (int k = 0; k < 5; k++)
                t = Q30_ONE - ((u2 * t) >> 30) / divs[k];
            s = (u * t) >> 30;
            if (s > Q30_ONE)
                s = Q30_ONE;
            v = (d >= 0) ? Q30_ONE + s : Q30_ONE - s;
            v = (v + 16384) >> 15;
            fade_lut[i] = (v > 65536) ? 65536 : v;
        end
    endtask

    function automatic longint unsigned interp_tap(input bit right_ch,
                                                   input longint unsigned pos,
                                                   input longint unsigned len);
        longint unsigned i0;
        longint unsigned i1;
        longint unsigned frac;
        longint unsigned a;
        longint unsigned b;
        i0   = pos >> 16;
        i1   = (i0 + 1 >= len) ? 0 : i0 + 1;
        frac = pos & 16'hFFFF;
        if (i0 >= STORE_DEPTH)
            i0 = 0;
        a = right_ch ? (right_mem[i0] ^ SIGN_FLIP) : (left_mem[i0] ^ SIGN_FLIP);
        b = right_ch ? (right_mem[i1] ^ SIGN_FLIP) : (left_mem[i1] ^ SIGN_FLIP);
        return (a * (65536 - frac) + b * frac + 32768) >> 16;
    endfunction

    function automatic stereo_t shift_pitch(input logic [SAMPLE_W-1:0] lin,
                                            input logic [SAMPLE_W-1:0] rin);
        stereo_t         res;
        longint unsigned g;
        longint unsigned len;
        longint unsigned gq;
        longint unsigned lq;
        longint unsigned m;
        longint unsigned pos2;
        longint unsigned idx;
        longint unsigned f1;
        longint unsigned wl;
        longint unsigned wr;
        longint unsigned ol;
        longint unsigned orr;
        if (!sh_enable)
        begin
            res.left  = lin;
            res.right = rin;
            return res;
        end
        g = sh_grain;
        if (g < GRAIN_MIN)
            g = GRAIN_MIN;
        if (g > GRAIN_LIMIT)
            g = GRAIN_LIMIT;
        len = 10 * g;
        gq  = g << 16;
        lq  = len << 16;
        m   = (sh_mix > 65536) ? 65536 : sh_mix;
        if (rd_pos >= lq)
        begin
            rd_pos = 0;
            phase  = 0;
        end
        if (phase >= gq)
            phase = 0;
        if (wr_ptr >= len)
            wr_ptr = 0;
        left_mem[wr_ptr]  = lin;
        right_mem[wr_ptr] = rin;
        pos2 = rd_pos + gq;
        if (pos2 >= lq)
            pos2 -= lq;
        idx = (((phase * sh_inverse) >> 16) * FADE_ENTRIES) >> 24;
        if (idx >= FADE_ENTRIES)
            idx = FADE_ENTRIES - 1;
        f1 = fade_lut[idx];
        wl = (interp_tap(0, rd_pos, len) * f1 + interp_tap(0, pos2, len) * (65536 - f1)
              + 32768) >> 16;
        wr = (interp_tap(1, rd_pos, len) * f1 + interp_tap(1, pos2, len) * (65536 - f1)
              + 32768) >> 16;
        ol  = (longint'(lin ^ SIGN_FLIP) * (65536 - m) + wl * m + 32768) >> 16;
        orr = (longint'(rin ^ SIGN_FLIP) * (65536 - m) + wr * m + 32768) >> 16;
        res.left  = 24'(ol) ^ SIGN_FLIP;
        res.right = 24'(orr) ^ SIGN_FLIP;
        rd_pos += sh_step;
        if (rd_pos >= lq)
            rd_pos -= lq;
        phase += sh_step;
        if (phase >= gq)
            phase -= gq;
        wr_ptr = (wr_ptr + 1 >= len) ? 0 : wr_ptr + 1;
        return res;
    endfunction

    task automatic send_frame(input logic [SAMPLE_W-1:0] lin,
                              input logic [SAMPLE_W-1:0] rin);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rin, lin};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_frames.push_back(shift_pitch(lin, rin));
    endtask

    // drain outstanding results and let the back end settle
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ENABLE:        sh_enable  = value[0];
            REG_PITCH_STEP:    sh_step    = value[STEP_W-1:0];
            REG_MIX_LEVEL:     sh_mix     = value[MIX_W-1:0];
            REG_GRAIN_LENGTH:  sh_grain   = value[GRAIN_W-1:0];
            REG_GRAIN_INVERSE: sh_inverse = value[INV_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [SAMPLE_W-1:0] extremes [6] = '{24'h7FFFFF, 24'h800000, 24'h000000,
                                             24'hFFFFFF, 24'h555555, 24'hAAAAAA};
        for (int i = 0; i < 6; i++)
            send_frame(extremes[i], extremes[5 - i]);
        quiesce();
        write_reg(REG_ENABLE, 0);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h123456, 24'hFEDCBA);
        quiesce();
        write_reg(REG_ENABLE, 1);
        write_reg(REG_GRAIN_LENGTH, 0);
        write_reg(REG_MIX_LEVEL, 32'h1FFFF);
        write_reg(REG_PITCH_STEP, 32'h3FFFF);
        write_reg(REG_GRAIN_INVERSE, 32'h1FFFFF);
        for (int i = 0; i < 5; i++)
            send_frame(extremes[i], extremes[i + 1]);
        quiesce();
        write_reg(REG_GRAIN_LENGTH, 32'h7FF);
        write_reg(REG_MIX_LEVEL, 0);
        write_reg(REG_PITCH_STEP, 0);
        for (int i = 0; i < 4; i++)
            send_frame(extremes[i], extremes[i + 2]);
        quiesce();
        write_reg(REG_MIX_LEVEL, 32768);
        write_reg(REG_GRAIN_LENGTH, 16);
        write_reg(REG_GRAIN_INVERSE, 1048576);
        write_reg(REG_PITCH_STEP, 131072);
        for (int i = 0; i < 6; i++)
            send_frame(extremes[i], extremes[i]);
        quiesce();
    endtask

    task automatic test_random_phases();
        int g;
        int n;
        for (int p = 0; p < 14; p++)
        begin
            case ($urandom_range(0, 7))
                0:       g = $urandom_range(0, 2047);
                1:       g = 1638;
                default: g = $urandom_range(16, 60);
            endcase
            write_reg(REG_GRAIN_LENGTH, g);
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_GRAIN_INVERSE, $urandom & 32'h1FFFFF);
            else
                write_reg(REG_GRAIN_INVERSE, (16777216 + g / 2) / (g < 16 ? 16 : g));
            case ($urandom_range(0, 5))
                0:       write_reg(REG_PITCH_STEP, $urandom & 32'h3FFFF);
                1:       write_reg(REG_PITCH_STEP, 32768);
                2:       write_reg(REG_PITCH_STEP, 131072);
                default: write_reg(REG_PITCH_STEP, $urandom_range(32768, 131072));
            endcase
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_MIX_LEVEL, $urandom & 32'h1FFFF);
            else
                write_reg(REG_MIX_LEVEL, $urandom_range(0, 65536));
            write_reg(REG_ENABLE, ($urandom_range(0, 6) != 0) ? 32'h1FFFFF : 32'h1FFFFE);
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
            stall_max    = ($urandom_range(0, 3) == 0) ? 0 : 13;
            n = $urandom_range(100, 165);
            for (int i = 0; i < n; i++)
                send_frame(rand_sample(), rand_sample());
            quiesce();
        end
        send_gap_max = 13;
        stall_max    = 13;
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            stall = $urandom_range(0, stall_max);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_frames.size() == 0)
            begin
                report_mismatch("unexpected result", m_axis_tdata[23:0], 24'h000000);
            end
            else
            begin
                stereo_t want;
                want = pending_frames.pop_front();
                if (m_axis_tdata[23:0] !== want.left)
                    report_mismatch("left_out", m_axis_tdata[23:0], want.left);
                if (m_axis_tdata[47:24] !== want.right)
                    report_mismatch("right_out", m_axis_tdata[47:24], want.right);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        mismatches    = 0;
        send_gap_max  = 13;
        stall_max     = 13;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            left_mem[i]  = '0;
            right_mem[i] = '0;
        end
        wr_ptr     = 0;
        rd_pos     = 0;
        phase      = 0;
        sh_enable  = 1'b1;
        sh_step    = 65536;
        sh_mix     = 65536;
        sh_grain   = 960;
        sh_inverse = 17476;
        build_fade_lut();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phases();

        quiesce();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/sdlps_pkg.sv
rtl/sdlps_ram.sv
rtl/sdlps_front.sv
rtl/sdlps_core.sv
rtl/stereo_delay_line_pitch_shifter.sv
tb/testbench.sv
